@@ design/ppis_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the paletted packed index store.
// No dependencies; the divider, the top level and the testbench use this package.
package ppis_pkg;

  localparam int WORD_BITS  = 64;
  localparam int OFF_W      = 6;   // bit offset inside a 64-bit word
  localparam int PER_W      = 7;   // cells per word, up to 64
  localparam int IW_W       = 5;   // index width register, up to 16
  localparam int CELL_IN_W  = 12;
  localparam int VALUE_IN_W = 16;
  localparam int STATUS_W   = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [CELL_IN_W-1:0]  cell_index;
    logic [VALUE_IN_W-1:0] new_value;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_IN_W-1:0] read_value;
    logic [STATUS_W-1:0]   status;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_SRCH, S_SRCH_CMP, S_APPEND, S_RP_DIV_O, S_RP_DIV_N,
    S_RP_RD, S_RP_EX, S_CELLW, S_CDIV, S_RD_EXT, S_RD_PAL, S_WR_MOD, S_DONE
  } state_t;

  // Number of indices that fit in one word at a given width.
  function automatic logic [PER_W-1:0] per_of(input logic [IW_W-1:0] w);
    logic [PER_W-1:0] p;
    unique case (w)
      5'd1:    p = 7'd64;
      5'd2:    p = 7'd32;
      5'd3:    p = 7'd21;
      5'd4:    p = 7'd16;
      5'd5:    p = 7'd12;
      5'd6:    p = 7'd10;
      5'd7:    p = 7'd9;
      5'd8:    p = 7'd8;
      5'd9:    p = 7'd7;
      5'd10:   p = 7'd6;
      5'd11:   p = 7'd5;
      5'd12:   p = 7'd5;
      5'd13:   p = 7'd4;
      5'd14:   p = 7'd4;
      5'd15:   p = 7'd4;
      5'd16:   p = 7'd4;
      default: p = 7'd64;
    endcase
    return p;
  endfunction

  function automatic logic [WORD_BITS-1:0] field_mask(input logic [IW_W-1:0] w);
    return (WORD_BITS'(1) << w) - WORD_BITS'(1);
  endfunction

  function automatic logic [15:0] extract(input logic [WORD_BITS-1:0] word,
                                          input logic [OFF_W-1:0] off,
                                          input logic [IW_W-1:0] w);
    logic [WORD_BITS-1:0] t;
    t = (word >> off) & field_mask(w);
    return t[15:0];
  endfunction

endpackage

@@ design/ppis_chan_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat of type T.
// Depends on nothing; the payload types come from ppis_pkg at instantiation.
interface ppis_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

@@ design/ppis_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by all cell address lookups.
// Depends on ppis_pkg for the divisor width.
module ppis_divider #(
  parameter int DW = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DW-1:0]            dividend,
  input  logic [ppis_pkg::PER_W-1:0] divisor,
  output logic                     done,
  output logic [DW-1:0]            quotient,
  output logic [ppis_pkg::PER_W-1:0] remainder
);
  localparam int CW = $clog2(DW + 1);

  logic                       busy;
  logic [CW-1:0]              cnt;
  logic [ppis_pkg::PER_W:0]   rem;
  logic [DW-1:0]              quo;
  logic [ppis_pkg::PER_W-1:0] dsr;
  logic [ppis_pkg::PER_W:0]   shifted;
  logic                       fits;

  assign shifted   = {rem[ppis_pkg::PER_W-1:0], quo[DW-1]};
  assign fits      = shifted >= {1'b0, dsr};
  assign quotient  = quo;
  assign remainder = rem[ppis_pkg::PER_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dsr}) : shifted;
      quo <= {quo[DW-2:0], fits};
    end
  end
endmodule

@@ design/paletted_packed_index_store_top.sv @@
`timescale 1ns / 1ps
// Top level of the paletted packed index store: sequencer, palette and word memories.
// Depends on ppis_pkg, ppis_chan_if and ppis_divider.
//
// Usage. Requests arrive as beats on req: a command bit (read or write), a cell index
// and a value. Every request yields exactly one response beat on rsp carrying the
// value read (zero for writes and for a read of an empty store) and a status code.
// The block works on one request at a time; req.ready is high only while idle.
// A read at a nonzero index width is dominated by the serial divider that turns
// a cell number into a word address and slot (one quotient bit per cycle). A write
// adds a linear palette search over the stored entries. When the palette grows
// past a power of two the whole store is repacked in place, walking the cells from
// the last to the first after divider runs find the start in the old and new width
// (new only when leaving width zero); this happens at most MAX_INDEX_BITS times
// after reset. Cell indices beyond CELL_COUNT wrap, one subtraction per cycle.
// Reset empties the palette and zeroes the index width; the word memory needs no
// clearing, since the first repack (from width zero) writes every word used.
// The response waits in an output register while rsp.ready is low; the next request
// is accepted meanwhile and is held at its end until the register frees up.
module paletted_packed_index_store_top #(
  parameter int CELL_COUNT     = 4096,
  parameter int MAX_INDEX_BITS = 8,
  parameter int VALUE_BITS     = 16
) (
  input logic clk,
  input logic rst,
  ppis_chan_if.sink   req,
  ppis_chan_if.source rsp
);
  localparam int CB      = $clog2(CELL_COUNT);
  localparam int DW      = (CB > ppis_pkg::CELL_IN_W) ? CB : ppis_pkg::CELL_IN_W;
  localparam int VW      = (VALUE_BITS < ppis_pkg::VALUE_IN_W) ? VALUE_BITS
                                                               : ppis_pkg::VALUE_IN_W;
  localparam int PD      = 1 << MAX_INDEX_BITS;
  localparam int PCW     = MAX_INDEX_BITS + 1;
  localparam int MIN_PER = ppis_pkg::WORD_BITS / MAX_INDEX_BITS;
  localparam int WDEPTH  = (CELL_COUNT + MIN_PER - 1) / MIN_PER;
  localparam int WAW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int OW      = ppis_pkg::OFF_W;
  localparam int IWW     = ppis_pkg::IW_W;

  // Memories: palette of identifiers and the packed index words.
  logic [VW-1:0]                   palette [PD];
  logic [ppis_pkg::WORD_BITS-1:0]  words [WDEPTH];
  logic [VW-1:0]                   pal_q;
  logic [ppis_pkg::WORD_BITS-1:0]  word_q;

  ppis_pkg::state_t state, state_next;

  // Request context.
  logic                  cmd;
  logic [DW-1:0]         cur_cell;
  logic [VW-1:0]         val;
  logic [MAX_INDEX_BITS-1:0] idx;
  logic [PCW-1:0]        count;
  logic [IWW-1:0]        width;
  logic [PCW-1:0]        srch;
  logic [WAW-1:0]        wa;
  logic [OW-1:0]         off;
  logic [VW-1:0]         res_val;
  logic [ppis_pkg::STATUS_W-1:0] res_st;

  // Repack walk.
  logic [IWW-1:0]        old_w;
  logic [DW-1:0]         rp_cell;
  logic [WAW-1:0]        ow_addr, nw_addr;
  logic [OW-1:0]         os, ns;
  logic [ppis_pkg::WORD_BITS-1:0] asm_word;

  // Output register.
  logic                  ovalid;
  ppis_pkg::out_beat_t   obeat;

  // Divider.
  logic                  div_start, div_done;
  logic [DW-1:0]         div_a, div_q;
  logic [ppis_pkg::PER_W-1:0] div_b, div_r;

  ppis_divider #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // Combinational helpers.
  logic [IWW-1:0]        grow_w;
  logic                  out_free;
  logic                  cell_wraps;
  logic [ppis_pkg::PER_W-1:0] per_old, per_new;
  logic [OW-1:0]         div_off, os_off, ns_off;
  logic [15:0]           cell_idx_raw, rp_idx_raw;
  logic [ppis_pkg::WORD_BITS-1:0] asm_upd, wr_word;
  logic                  pal_we, word_we, word_re, pal_re;
  logic [MAX_INDEX_BITS-1:0] pal_raddr;
  logic [ppis_pkg::WORD_BITS-1:0] word_wdata;
  logic [WAW-1:0]        word_waddr, word_raddr;

  // Width that the palette needs once it holds count + 1 entries: bit width of count.
  always_comb begin
    grow_w = '0;
    for (int i = 0; i < PCW; i++) begin
      if (count[i]) grow_w = IWW'(i + 1);
    end
  end

  // The compare is one bit wider so that a power-of-two cell count never wraps.
  assign cell_wraps = ({1'b0, cur_cell} >= (DW + 1)'(CELL_COUNT));
  assign out_free = !ovalid || rsp.ready;
  assign per_old  = ppis_pkg::per_of(old_w);
  assign per_new  = ppis_pkg::per_of(width);
  assign div_off  = OW'(div_r[OW-1:0] * width);
  assign os_off   = OW'(os * old_w);
  assign ns_off   = OW'(ns * width);
  assign cell_idx_raw = ppis_pkg::extract(word_q, off, width);
  assign rp_idx_raw   = (old_w == '0) ? 16'd0 : ppis_pkg::extract(word_q, os_off, old_w);
  assign asm_upd  = asm_word | ((ppis_pkg::WORD_BITS'(rp_idx_raw) &
                                 ppis_pkg::field_mask(width)) << ns_off);
  assign wr_word  = (word_q & ~(ppis_pkg::field_mask(width) << off)) |
                    ((ppis_pkg::WORD_BITS'(idx) & ppis_pkg::field_mask(width)) << off);

  assign req.ready   = (state == ppis_pkg::S_IDLE);
  assign rsp.valid   = ovalid;
  assign rsp.payload = obeat;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ppis_pkg::S_IDLE:
        if (req.valid) state_next = ppis_pkg::S_WRAP;
      ppis_pkg::S_WRAP: begin
        if (cell_wraps) state_next = ppis_pkg::S_WRAP;
        else if (cmd == ppis_pkg::CMD_WRITE) state_next = ppis_pkg::S_SRCH;
        else if (count == '0) state_next = ppis_pkg::S_DONE;
        else if (width == '0) state_next = ppis_pkg::S_RD_PAL;
        else state_next = ppis_pkg::S_CDIV;
      end
      ppis_pkg::S_SRCH:
        state_next = (srch == count) ? ppis_pkg::S_APPEND : ppis_pkg::S_SRCH_CMP;
      ppis_pkg::S_SRCH_CMP:
        state_next = (pal_q == val) ? ppis_pkg::S_CELLW : ppis_pkg::S_SRCH;
      ppis_pkg::S_APPEND: begin
        if (count == PCW'(PD)) state_next = ppis_pkg::S_DONE;
        else if (grow_w == width) state_next = ppis_pkg::S_CELLW;
        else if (width == '0) state_next = ppis_pkg::S_RP_DIV_N;
        else state_next = ppis_pkg::S_RP_DIV_O;
      end
      ppis_pkg::S_RP_DIV_O:
        if (div_done) state_next = ppis_pkg::S_RP_DIV_N;
      ppis_pkg::S_RP_DIV_N:
        if (div_done) state_next = ppis_pkg::S_RP_RD;
      ppis_pkg::S_RP_RD:
        state_next = ppis_pkg::S_RP_EX;
      ppis_pkg::S_RP_EX:
        state_next = (rp_cell == '0) ? ppis_pkg::S_CELLW : ppis_pkg::S_RP_RD;
      ppis_pkg::S_CELLW:
        state_next = (width == '0) ? ppis_pkg::S_DONE : ppis_pkg::S_CDIV;
      ppis_pkg::S_CDIV:
        if (div_done) begin
          state_next = (cmd == ppis_pkg::CMD_WRITE) ? ppis_pkg::S_WR_MOD
                                                    : ppis_pkg::S_RD_EXT;
        end
      ppis_pkg::S_RD_EXT:
        state_next = ppis_pkg::S_RD_PAL;
      ppis_pkg::S_RD_PAL:
        state_next = ppis_pkg::S_DONE;
      ppis_pkg::S_WR_MOD:
        state_next = ppis_pkg::S_DONE;
      ppis_pkg::S_DONE:
        if (out_free) state_next = ppis_pkg::S_IDLE;
      default:
        state_next = ppis_pkg::S_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    div_start  = 1'b0;
    div_a      = cur_cell;
    div_b      = per_new;
    pal_re     = 1'b0;
    pal_raddr  = srch[MAX_INDEX_BITS-1:0];
    pal_we     = 1'b0;
    word_re    = 1'b0;
    word_raddr = ow_addr;
    word_we    = 1'b0;
    word_waddr = wa;
    word_wdata = wr_word;
    unique case (state)
      ppis_pkg::S_WRAP: begin
        if (!cell_wraps && cmd == ppis_pkg::CMD_READ && count != '0) begin
          if (width == '0) begin
            pal_re    = 1'b1;
            pal_raddr = '0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ppis_pkg::S_SRCH:
        pal_re = (srch != count);
      ppis_pkg::S_APPEND: begin
        if (count != PCW'(PD)) begin
          pal_we = 1'b1;
          if (grow_w != width) begin
            div_start = 1'b1;
            div_a     = DW'(CELL_COUNT - 1);
            div_b     = (width == '0) ? ppis_pkg::per_of(grow_w) : per_new;
          end
        end
      end
      ppis_pkg::S_RP_DIV_O: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = DW'(CELL_COUNT - 1);
          div_b     = per_new;
        end
      end
      ppis_pkg::S_RP_RD:
        word_re = 1'b1;
      ppis_pkg::S_RP_EX: begin
        if (ns == '0) begin
          word_we    = 1'b1;
          word_waddr = nw_addr;
          word_wdata = asm_upd;
        end
      end
      ppis_pkg::S_CELLW:
        div_start = (width != '0);
      ppis_pkg::S_CDIV: begin
        word_re    = div_done;
        word_raddr = div_q[WAW-1:0];
      end
      ppis_pkg::S_RD_EXT: begin
        pal_re    = 1'b1;
        pal_raddr = cell_idx_raw[MAX_INDEX_BITS-1:0];
      end
      ppis_pkg::S_WR_MOD:
        word_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pal_we) palette[count[MAX_INDEX_BITS-1:0]] <= val;
    if (pal_re) pal_q <= palette[pal_raddr];
  end

  always_ff @(posedge clk) begin
    if (word_we) words[word_waddr] <= word_wdata;
    if (word_re) word_q <= words[word_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ppis_pkg::S_IDLE;
      count  <= '0;
      width  <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ppis_pkg::S_DONE && out_free) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
      if (state == ppis_pkg::S_APPEND && count != PCW'(PD)) begin
        count <= count + PCW'(1);
        width <= grow_w;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ppis_pkg::S_IDLE: begin
        cmd      <= req.payload.command;
        cur_cell <= DW'(req.payload.cell_index);
        val      <= VW'(req.payload.new_value);
        srch     <= '0;
        res_val  <= '0;
        res_st   <= ppis_pkg::ST_OK;
      end
      ppis_pkg::S_WRAP: begin
        if (cell_wraps) cur_cell <= cur_cell - DW'(CELL_COUNT);
        else if (cmd == ppis_pkg::CMD_READ && count == '0) res_st <= ppis_pkg::ST_EMPTY;
      end
      ppis_pkg::S_SRCH_CMP: begin
        if (pal_q == val) idx <= srch[MAX_INDEX_BITS-1:0];
        else srch <= srch + PCW'(1);
      end
      ppis_pkg::S_APPEND: begin
        old_w <= width;
        idx   <= count[MAX_INDEX_BITS-1:0];
        if (count == PCW'(PD)) res_st <= ppis_pkg::ST_FULL;
      end
      ppis_pkg::S_RP_DIV_O: begin
        ow_addr <= div_q[WAW-1:0];
        os      <= div_r[OW-1:0];
      end
      ppis_pkg::S_RP_DIV_N: begin
        nw_addr  <= div_q[WAW-1:0];
        ns       <= div_r[OW-1:0];
        rp_cell  <= DW'(CELL_COUNT - 1);
        asm_word <= '0;
      end
      ppis_pkg::S_RP_EX: begin
        asm_word <= (ns == '0) ? '0 : asm_upd;
        rp_cell  <= rp_cell - DW'(1);
        if (os == '0) begin
          os      <= OW'(per_old - ppis_pkg::PER_W'(1));
          ow_addr <= ow_addr - WAW'(1);
        end else begin
          os <= os - OW'(1);
        end
        if (ns == '0) begin
          ns      <= OW'(per_new - ppis_pkg::PER_W'(1));
          nw_addr <= nw_addr - WAW'(1);
        end else begin
          ns <= ns - OW'(1);
        end
      end
      ppis_pkg::S_CDIV: begin
        wa  <= div_q[WAW-1:0];
        off <= div_off;
      end
      ppis_pkg::S_RD_PAL:
        res_val <= pal_q;
      ppis_pkg::S_DONE: begin
        if (out_free) begin
          obeat.read_value <= ppis_pkg::VALUE_IN_W'(res_val);
          obeat.status     <= res_st;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

@@ verif/paletted_packed_index_store_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the paletted packed index store top level.
// Depends on ppis_pkg, ppis_chan_if and the top level; it carries its own store predictor.
module paletted_packed_index_store_top_tb;

  localparam int CELLS = 4096;
  localparam int PAL_DEPTH = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppis_chan_if #(.T(ppis_pkg::in_beat_t))  req_ch ();
  ppis_chan_if #(.T(ppis_pkg::out_beat_t)) rsp_ch ();

  paletted_packed_index_store_top u_top (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The predictor keeps the contents of every cell as a palette index directly.
  // Packing is a detail of the block; repacking must not change any cell's index,
  // so a flat array of indices gives the same answers.
  logic [15:0] pal_values [PAL_DEPTH];
  int unsigned pal_used;
  logic [7:0]  cell_slot [CELLS];

  ppis_pkg::in_beat_t  send_queue [$];
  ppis_pkg::out_beat_t expected_rsp [$];
  int unsigned mismatches = 0;
  bit stall_long = 1'b0;
  bit hold_sender = 1'b0;
  bit req_fire = 1'b0;

  // Expected response for one accepted request; also updates the predicted store.
  function automatic ppis_pkg::out_beat_t predict_store(input ppis_pkg::in_beat_t b);
    ppis_pkg::out_beat_t r;
    int unsigned hit;
    r.read_value = '0;
    r.status = ppis_pkg::ST_OK;
    if (b.command == ppis_pkg::CMD_READ) begin
      if (pal_used == 0) begin
        r.status = ppis_pkg::ST_EMPTY;
      end else if (pal_used == 1) begin
        r.read_value = pal_values[0];
      end else begin
        r.read_value = pal_values[cell_slot[b.cell_index]];
      end
    end else begin
      hit = pal_used;
      for (int i = 0; i < pal_used; i++) begin
        if (pal_values[i] == b.new_value && hit == pal_used) hit = i;
      end
      if (hit == pal_used && pal_used == PAL_DEPTH) begin
        r.status = ppis_pkg::ST_FULL;
      end else begin
        if (hit == pal_used) begin
          pal_values[pal_used] = b.new_value;
          // When the width first leaves zero, every cell holds index 0,
          // which the flat array already says.
          pal_used++;
        end
        if (pal_used > 1) cell_slot[b.cell_index] = hit[7:0];
      end
    end
    return r;
  endfunction

  // Driver: bursts of offers with random gaps, changing inputs on the falling edge.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit accepted;
  always @(negedge clk) begin
    accepted = req_fire;
    if (accepted) void'(send_queue.pop_front());
    if (rst || hold_sender || send_queue.size() == 0) begin
      req_ch.valid <= 1'b0;
    end else if (gap_left != 0 && !req_ch.valid) begin
      gap_left--;
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !accepted) begin
      req_ch.valid <= 1'b1;
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 0;
      end
      burst_left--;
      if (gap_left != 0) begin
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid <= 1'b1;
        req_ch.payload <= send_queue[0];
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  int unsigned stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst || stall_long) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_phase[9:7] == 3'd5) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= ((stall_phase % 7) != 3) && ($urandom_range(0, 4) != 0);
    end
  end

  // Monitor: requests are predicted as they are accepted; responses are checked.
  ppis_pkg::out_beat_t want;
  always @(posedge clk) begin
    req_fire = req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (req_fire) expected_rsp.insert(expected_rsp.size(), predict_store(req_ch.payload));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("response beat with nothing expected: %h",
                                         rsp_ch.payload);
        end else begin
          want = expected_rsp.pop_front();
          if (want.read_value !== rsp_ch.payload.read_value ||
              want.status !== rsp_ch.payload.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h status %0d, got value %h status %0d",
                       want.read_value, want.status,
                       rsp_ch.payload.read_value, rsp_ch.payload.status);
          end
        end
      end
    end
  end

  function automatic ppis_pkg::in_beat_t make_beat(input logic c,
                                                   input logic [11:0] cell_no,
                                                   input logic [15:0] v);
    ppis_pkg::in_beat_t b;
    b.command = c;
    b.cell_index = cell_no;
    b.new_value = v;
    return b;
  endfunction

  task automatic queue_req(input ppis_pkg::in_beat_t b);
    send_queue.insert(send_queue.size(), b);
  endtask

  task automatic wait_drained();
    while (send_queue.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
  endtask

  // Random traffic that reuses identifiers already in the palette, apart from a share
  // of fresh_pct percent new ones, so that the palette grows slowly through each width.
  task automatic random_traffic(input int unsigned count, input int unsigned fresh_pct);
    logic [15:0] v;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < fresh_pct || pal_used == 0) v = 16'($urandom);
      else v = pal_values[$urandom_range(0, (pal_used > 0 ? pal_used : 1) - 1)];
      queue_req(make_beat(1'($urandom_range(0, 1)), 12'($urandom), v));
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    pal_used = 0;
    foreach (pal_values[i]) pal_values[i] = '0;
    foreach (cell_slot[i]) cell_slot[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: read of an empty store, then a single-entry palette where a write
    // only touches the palette, then width growth with extreme cells and values.
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'd0, 16'hFFFF));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'hFFF, 16'h0));
    queue_req(make_beat(ppis_pkg::CMD_WRITE, 12'hFFF, 16'hFFFF));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'd0, 16'h0));
    queue_req(make_beat(ppis_pkg::CMD_WRITE, 12'd5, 16'hFFFF));
    queue_req(make_beat(ppis_pkg::CMD_WRITE, 12'd0, 16'h0000));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'hFFF, 16'h0));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'd0, 16'h0));
    queue_req(make_beat(ppis_pkg::CMD_WRITE, 12'hFFF, 16'h5A5A));
    queue_req(make_beat(ppis_pkg::CMD_WRITE, 12'hAAA, 16'hA5A5));
    queue_req(make_beat(ppis_pkg::CMD_WRITE, 12'h555, 16'h0000));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'hFFF, 16'h0));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'hAAA, 16'h0));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'h555, 16'h0));
    queue_req(make_beat(ppis_pkg::CMD_READ, 12'd5, 16'h0));
    wait_drained();

    // With every response back, the sender is held off here before the next phase.
    hold_sender = 1'b1;
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;

    // Long receiver hold-off while requests keep coming, so the input stalls.
    random_traffic(40, 10);
    stall_long = 1'b1;
    repeat (400) @(posedge clk);
    stall_long = 1'b0;
    wait_drained();

    // Bulk random traffic that grows the palette further.
    random_traffic(300, 12);
    wait_drained();
    // Fill the palette, then hit it with new identifiers that must be refused.
    while (pal_used < PAL_DEPTH) begin
      random_traffic(100, 80);
      wait_drained();
    end
    random_traffic(300, 30);
    wait_drained();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Generous bound on the run, including every repack of all 4096 cells.
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
